[rtl/mlfq_pkg.sv]
// Shared types and codes for the feedback-queue scheduler.
// No dependencies.
`default_nettype none
package mlfq_pkg;

    localparam int BURST_W = 10;
    localparam int TIME_W  = 16;

    typedef enum logic [1:0] {
        RS_WAIT = 2'd0,
        RS_EXEC = 2'd1,
        RS_IO   = 2'd2,
        RS_DONE = 2'd3
    } t_run_state;

    localparam logic [2:0] FN_LOAD_CPU = 3'd0;
    localparam logic [2:0] FN_LOAD_IO  = 3'd1;
    localparam logic [2:0] FN_COUNTS   = 3'd2;
    localparam logic [2:0] FN_STEP     = 3'd3;
    localparam logic [2:0] FN_READ     = 3'd4;

    localparam logic [1:0] CFG_QUANT_ONE = 2'd0;
    localparam logic [1:0] CFG_QUANT_TWO = 2'd1;
    localparam logic [1:0] CFG_TIME_LIM  = 2'd2;
    localparam logic [1:0] CFG_PROCS     = 2'd3;

endpackage
`default_nettype wire

[rtl/mlfq_ram.sv]
// Single-port burst table RAM with registered read.
// Uses mlfq_pkg for the data width.
`default_nettype none
module mlfq_ram #(
    parameter int AW = 7
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_we,
    input  wire logic [AW-1:0]                i_addr,
    input  wire logic [mlfq_pkg::BURST_W-1:0] i_wdata,
    output logic      [mlfq_pkg::BURST_W-1:0] o_rdata
);
    logic [mlfq_pkg::BURST_W-1:0] r_mem [2**AW];
    logic [mlfq_pkg::BURST_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

[rtl/mlfq_process_scheduler_top.sv]
// Three-level feedback-queue scheduler: process table, burst RAMs, round sequencer.
// Depends on mlfq_pkg and mlfq_ram.
//
// Usage: items arrive on i_valid/o_ready with i_func selecting load cpu burst,
// load io burst, set burst counts, step, or read stats. Every item yields exactly
// one result transaction on o_valid/i_ready. Configuration writes use
// i_cfg_valid/o_cfg_ready with i_cfg_index and i_cfg_data; the port is always
// ready. Write it only while the block is idle; the block does not enforce it.
// Loads, counts and reads pass through S_RESP to the result register.
// A step scans the entries in use for the selection, may read-modify-write the
// CPU burst RAM, and when time advances makes an I/O countdown pass over the
// entries through the I/O burst RAM. One item is processed at a time.
// Reset (synchronous, active low) clears all per-process state and counters and
// restores the default configuration; the burst RAMs are not cleared.
// A finished result waits in the output register while the receiver stalls;
// the next item is still accepted and processed, and its result holds until
// the output register frees, with o_ready low meanwhile.
`default_nettype none
module mlfq_process_scheduler_top #(
    parameter int NUM_PROCS  = 8,
    parameter int MAX_BURSTS = 16,
    parameter int NUM_LEVELS = 3
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [2:0]  i_func,
    input  wire logic [2:0]  i_proc_index,
    input  wire logic [3:0]  i_entry_index,
    input  wire logic [9:0]  i_entry_value,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [15:0]      o_current_time,
    output logic [2:0]       o_chosen_process,
    output logic             o_cpu_idle,
    output logic [1:0]       o_chosen_level,
    output logic             o_all_done,
    output logic [15:0]      o_idle_ticks,
    output logic [15:0]      o_response_time,
    output logic [15:0]      o_wait_time,
    output logic [15:0]      o_turnaround_time,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);
    localparam int PW = (NUM_PROCS > 2) ? $clog2(NUM_PROCS) : 1;
    localparam int BW = (MAX_BURSTS > 2) ? $clog2(MAX_BURSTS) : 1;
    localparam int NW = PW + 1;
    localparam int CW = $clog2(MAX_BURSTS + 1);
    localparam int LW = $clog2(NUM_LEVELS + 1);
    localparam int DW = mlfq_pkg::BURST_W;
    localparam int TW = mlfq_pkg::TIME_W;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_PRE, S_PRE_WR, S_SEL, S_RUN, S_ADV, S_IO, S_IO_WR, S_FIN, S_RESP
    } t_state;

    t_state r_state;

    logic [7:0]  r_q1, r_q2;
    logic [15:0] r_limit;
    logic [3:0]  r_piu;

    mlfq_pkg::t_run_state r_rs [NUM_PROCS];
    logic [CW-1:0] r_ccnt   [NUM_PROCS];
    logic [CW-1:0] r_icnt   [NUM_PROCS];
    logic [LW-1:0] r_lvl    [NUM_PROCS];
    logic [TW-1:0] r_rsince [NUM_PROCS];
    logic [BW-1:0] r_bpos   [NUM_PROCS];
    logic [BW-1:0] r_iopos  [NUM_PROCS];
    logic [DW-1:0] r_slice  [NUM_PROCS];
    logic [TW-1:0] r_first  [NUM_PROCS];
    logic          r_hasrun [NUM_PROCS];
    logic [TW-1:0] r_waited [NUM_PROCS];
    logic [TW-1:0] r_finish [NUM_PROCS];

    logic [TW-1:0] r_tick, r_idle_cnt;
    logic [PW-1:0] r_prev;
    logic          r_prev_valid, r_dispatch;

    logic [NW-1:0] r_idx;
    logic          r_bvalid;
    logic [PW-1:0] r_ch;
    logic [LW-1:0] r_blvl;
    logic [TW-1:0] r_brs;

    logic [2:0]    r_res_ch;
    logic          r_res_idle;
    logic [1:0]    r_res_lvl;
    logic [TW-1:0] r_res_rt, r_res_wt, r_res_tt;

    logic          r_out_valid;
    logic [15:0]   r_out_time, r_out_idle_ticks, r_out_rt, r_out_wt, r_out_tt;
    logic [2:0]    r_out_ch;
    logic          r_out_idle, r_out_done;
    logic [1:0]    r_out_lvl;

    logic [NW-1:0] w_n;
    logic [31:0]   w_n_raw;
    logic [PW-1:0] w_pi, w_ip;
    logic [BW-1:0] w_ei;
    logic          w_pi_ok, w_ei_ok, w_finished, w_accept, w_rd_ok;
    logic [NUM_PROCS-1:0] w_done_vec, w_exec_vec;

    logic          c_we, i_we_io;
    logic [PW+BW-1:0] c_addr, io_addr;
    logic [DW-1:0] c_wd, io_wd, w_cpu_rd, w_io_rd, w_rem;
    logic [PW-1:0] w_sub;
    logic          w_lt, w_inq, w_better;
    logic [7:0]    w_quant;

    assign w_n_raw = (r_piu == 4'd0) ? 32'd1 :
                     ((32'(r_piu) > NUM_PROCS) ? 32'(NUM_PROCS) : 32'(r_piu));
    assign w_n     = w_n_raw[NW-1:0];
    assign w_pi    = PW'(i_proc_index);
    assign w_ei    = BW'(i_entry_index);
    assign w_pi_ok = 32'(i_proc_index) < NUM_PROCS;
    assign w_ei_ok = 32'(i_entry_index) < MAX_BURSTS;
    assign w_ip    = r_idx[PW-1:0];
    assign w_accept = i_valid && o_ready;
    assign w_rd_ok  = (i_func == mlfq_pkg::FN_READ) && w_pi_ok;

    always_comb begin
        for (int p = 0; p < NUM_PROCS; p++) begin
            w_done_vec[p] = (32'(p) >= 32'(w_n)) || (r_rs[p] == mlfq_pkg::RS_DONE);
            w_exec_vec[p] = (r_rs[p] == mlfq_pkg::RS_EXEC);
        end
    end
    assign w_finished = (r_tick >= r_limit) || (&w_done_vec);

    assign w_sub   = (r_state == S_PRE_WR) ? r_prev : r_ch;
    assign w_rem   = (w_cpu_rd > r_slice[w_sub]) ? (w_cpu_rd - r_slice[w_sub]) : '0;
    assign w_quant = (r_lvl[r_ch] <= LW'(1)) ? r_q1 : r_q2;
    assign w_lt    = r_slice[r_ch] < w_cpu_rd;
    assign w_inq   = (32'(r_lvl[r_ch]) >= NUM_LEVELS) || (r_slice[r_ch] < DW'(w_quant));
    assign w_better = (r_rs[w_ip] == mlfq_pkg::RS_WAIT || r_rs[w_ip] == mlfq_pkg::RS_EXEC)
                   && (!r_bvalid || r_lvl[w_ip] < r_blvl
                       || (r_lvl[w_ip] == r_blvl && r_rsince[w_ip] < r_brs));

    always_comb begin
        c_we   = 1'b0;
        c_addr = {r_ch, r_bpos[r_ch]};
        c_wd   = w_rem;
        case (r_state)
            S_IDLE: begin
                c_addr = {w_pi, w_ei};
                c_wd   = i_entry_value;
                c_we   = w_accept && i_func == mlfq_pkg::FN_LOAD_CPU && w_pi_ok && w_ei_ok;
            end
            S_PRE: begin
                c_addr = {r_prev, r_bpos[r_prev]};
            end
            S_PRE_WR: begin
                c_addr = {r_prev, r_bpos[r_prev]};
                c_we   = 1'b1;
            end
            S_RUN: begin
                c_we = w_lt && !w_inq;
            end
            default: begin
                c_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        i_we_io = 1'b0;
        io_addr = {w_ip, r_iopos[w_ip]};
        io_wd   = (w_io_rd <= DW'(1)) ? '0 : (w_io_rd - DW'(1));
        case (r_state)
            S_IDLE: begin
                io_addr = {w_pi, w_ei};
                io_wd   = i_entry_value;
                i_we_io = w_accept && i_func == mlfq_pkg::FN_LOAD_IO && w_pi_ok && w_ei_ok;
            end
            S_IO_WR: begin
                i_we_io = 1'b1;
            end
            default: begin
                i_we_io = 1'b0;
            end
        endcase
    end

    mlfq_ram #(.AW(PW + BW)) u_cpu_ram (
        .i_clk(i_clk), .i_we(c_we), .i_addr(c_addr), .i_wdata(c_wd), .o_rdata(w_cpu_rd)
    );

    mlfq_ram #(.AW(PW + BW)) u_io_ram (
        .i_clk(i_clk), .i_we(i_we_io), .i_addr(io_addr), .i_wdata(io_wd), .o_rdata(w_io_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_q1         <= 8'd5;
            r_q2         <= 8'd10;
            r_limit      <= 16'd590;
            r_piu        <= 4'd8;
            r_tick       <= '0;
            r_idle_cnt   <= '0;
            r_prev       <= '0;
            r_prev_valid <= 1'b0;
            r_dispatch   <= 1'b0;
            r_out_valid  <= 1'b0;
            for (int p = 0; p < NUM_PROCS; p++) begin
                r_rs[p]     <= mlfq_pkg::RS_WAIT;
                r_ccnt[p]   <= '0;
                r_icnt[p]   <= '0;
                r_lvl[p]    <= LW'(1);
                r_rsince[p] <= '0;
                r_bpos[p]   <= '0;
                r_iopos[p]  <= '0;
                r_slice[p]  <= '0;
                r_first[p]  <= '0;
                r_hasrun[p] <= 1'b0;
                r_waited[p] <= '0;
                r_finish[p] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    mlfq_pkg::CFG_QUANT_ONE: r_q1    <= i_cfg_data[7:0];
                    mlfq_pkg::CFG_QUANT_TWO: r_q2    <= i_cfg_data[7:0];
                    mlfq_pkg::CFG_TIME_LIM:  r_limit <= i_cfg_data;
                    mlfq_pkg::CFG_PROCS:     r_piu   <= i_cfg_data[3:0];
                    default:                 r_piu   <= r_piu;
                endcase
            end
            if (r_out_valid && i_ready && r_state != S_RESP) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_res_ch   <= '0;
                        r_res_idle <= 1'b0;
                        r_res_lvl  <= 2'd1;
                        r_res_rt   <= w_rd_ok ? r_first[w_pi] : '0;
                        r_res_wt   <= w_rd_ok ? r_waited[w_pi] : '0;
                        r_res_tt   <= w_rd_ok ? r_finish[w_pi] : '0;
                        r_idx      <= '0;
                        r_bvalid   <= 1'b0;
                        r_ch       <= '0;
                        r_blvl     <= '0;
                        r_brs      <= '0;
                        r_state    <= (i_func == mlfq_pkg::FN_STEP && !w_finished) ?
                                      S_SCAN : S_RESP;
                        if (i_func == mlfq_pkg::FN_COUNTS && w_pi_ok) begin
                            r_ccnt[w_pi] <= (32'(i_entry_value) > MAX_BURSTS) ?
                                            CW'(MAX_BURSTS) : CW'(i_entry_value);
                            r_icnt[w_pi] <= (32'(i_entry_index) > MAX_BURSTS) ?
                                            CW'(MAX_BURSTS) : CW'(i_entry_index);
                        end
                    end
                end
                S_SCAN: begin
                    if (w_better) begin
                        r_bvalid <= 1'b1;
                        r_ch     <= w_ip;
                        r_blvl   <= r_lvl[w_ip];
                        r_brs    <= r_rsince[w_ip];
                    end
                    if (r_idx + NW'(1) == w_n) begin
                        r_state <= S_PRE;
                    end else begin
                        r_idx <= r_idx + NW'(1);
                    end
                end
                S_PRE: begin
                    if (r_prev_valid && (!r_bvalid || r_ch != r_prev)
                        && r_rs[r_prev] == mlfq_pkg::RS_EXEC) begin
                        r_state <= S_PRE_WR;
                    end else begin
                        r_state <= S_SEL;
                    end
                end
                S_PRE_WR: begin
                    r_rsince[r_prev] <= r_tick;
                    r_slice[r_prev]  <= '0;
                    r_dispatch       <= 1'b0;
                    if (w_rem == '0) begin
                        if (32'(r_bpos[r_prev]) + 1 < 32'(r_ccnt[r_prev])) begin
                            r_bpos[r_prev] <= r_bpos[r_prev] + BW'(1);
                            r_rs[r_prev]   <= mlfq_pkg::RS_IO;
                        end else begin
                            r_rs[r_prev]     <= mlfq_pkg::RS_DONE;
                            r_finish[r_prev] <= r_tick;
                        end
                    end else begin
                        r_rs[r_prev] <= mlfq_pkg::RS_WAIT;
                    end
                    r_state <= S_SEL;
                end
                S_SEL: begin
                    r_prev       <= r_ch;
                    r_prev_valid <= r_bvalid;
                    if (!r_bvalid) begin
                        if (r_idle_cnt != '1) begin
                            r_idle_cnt <= r_idle_cnt + TW'(1);
                        end
                        r_state <= S_ADV;
                    end else if (r_rs[r_ch] == mlfq_pkg::RS_WAIT) begin
                        if (!r_dispatch) begin
                            r_slice[r_ch] <= '0;
                            r_rs[r_ch]    <= mlfq_pkg::RS_EXEC;
                            r_dispatch    <= 1'b1;
                        end
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (!r_hasrun[r_ch]) begin
                        r_first[r_ch]  <= r_tick;
                        r_hasrun[r_ch] <= 1'b1;
                    end
                    if (w_lt) begin
                        if (w_inq) begin
                            r_slice[r_ch] <= r_slice[r_ch] + DW'(1);
                            r_state       <= S_ADV;
                        end else begin
                            r_lvl[r_ch]    <= r_lvl[r_ch] + LW'(1);
                            r_slice[r_ch]  <= '0;
                            r_rsince[r_ch] <= r_tick;
                            r_dispatch     <= 1'b0;
                            r_rs[r_ch]     <= mlfq_pkg::RS_WAIT;
                            r_state        <= S_FIN;
                        end
                    end else begin
                        r_rsince[r_ch] <= r_tick;
                        r_slice[r_ch]  <= '0;
                        r_dispatch     <= 1'b0;
                        r_state        <= S_FIN;
                        if (32'(r_bpos[r_ch]) + 1 < 32'(r_ccnt[r_ch])) begin
                            r_bpos[r_ch] <= r_bpos[r_ch] + BW'(1);
                            r_rs[r_ch]   <= mlfq_pkg::RS_IO;
                        end else begin
                            r_rs[r_ch]     <= mlfq_pkg::RS_DONE;
                            r_finish[r_ch] <= r_tick;
                        end
                    end
                end
                S_ADV: begin
                    for (int p = 0; p < NUM_PROCS; p++) begin
                        if (32'(p) < 32'(w_n) && r_rs[p] == mlfq_pkg::RS_WAIT
                            && r_waited[p] != '1) begin
                            r_waited[p] <= r_waited[p] + TW'(1);
                        end
                    end
                    r_idx   <= '0;
                    r_state <= S_IO;
                end
                S_IO: begin
                    if (r_idx == w_n) begin
                        if (r_tick != '1) begin
                            r_tick <= r_tick + TW'(1);
                        end
                        r_state <= S_FIN;
                    end else if (r_rs[w_ip] == mlfq_pkg::RS_IO) begin
                        r_state <= S_IO_WR;
                    end else begin
                        r_idx <= r_idx + NW'(1);
                    end
                end
                S_IO_WR: begin
                    if (w_io_rd <= DW'(1)) begin
                        if (32'(r_iopos[w_ip]) + 1 < 32'(r_icnt[w_ip])) begin
                            r_iopos[w_ip] <= r_iopos[w_ip] + BW'(1);
                        end
                        r_rs[w_ip]     <= mlfq_pkg::RS_WAIT;
                        r_rsince[w_ip] <= r_tick;
                    end
                    r_idx   <= r_idx + NW'(1);
                    r_state <= S_IO;
                end
                S_FIN: begin
                    if (r_bvalid) begin
                        r_res_ch  <= 3'(r_ch);
                        r_res_lvl <= 2'(r_lvl[r_ch]);
                    end else begin
                        r_res_idle <= 1'b1;
                    end
                    r_state <= S_RESP;
                end
                S_RESP: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid      <= 1'b1;
                        r_out_time       <= r_tick;
                        r_out_ch         <= r_res_ch;
                        r_out_idle       <= r_res_idle;
                        r_out_lvl        <= r_res_lvl;
                        r_out_done       <= w_finished;
                        r_out_idle_ticks <= r_idle_cnt;
                        r_out_rt         <= r_res_rt;
                        r_out_wt         <= r_res_wt;
                        r_out_tt         <= r_res_tt;
                        r_state          <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready           = (r_state == S_IDLE);
    assign o_cfg_ready       = 1'b1;
    assign o_valid           = r_out_valid;
    assign o_current_time    = r_out_time;
    assign o_chosen_process  = r_out_ch;
    assign o_cpu_idle        = r_out_idle;
    assign o_chosen_level    = r_out_lvl;
    assign o_all_done        = r_out_done;
    assign o_idle_ticks      = r_out_idle_ticks;
    assign o_response_time   = r_out_rt;
    assign o_wait_time       = r_out_wt;
    assign o_turnaround_time = r_out_tt;

    a_one_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_exec_vec) == 32'(r_dispatch))
        else $error("executing process count disagrees with dispatch flag");

    a_tick_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> r_tick >= $past(r_tick))
        else $error("tick counter went backwards");

    a_idle_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> r_idle_cnt >= $past(r_idle_cnt))
        else $error("idle counter went backwards");

endmodule
`default_nettype wire

[sim/tb_mlfq_process_scheduler_top.sv]
// Testbench for the feedback-queue scheduler: random and directed transactions
// checked against a cycle-free behavioral predictor of the process table.
// Depends on mlfq_pkg and mlfq_process_scheduler_top.
`default_nettype none
module tb_mlfq_process_scheduler_top;

    localparam int NPROC     = 8;
    localparam int NBURST    = 16;
    localparam int NLEVEL    = 3;
    localparam int WDOG_MAX  = 8000;

    typedef struct packed {
        logic [2:0] func;
        logic [2:0] proc_idx;
        logic [3:0] entry_idx;
        logic [9:0] entry_val;
    } t_item;

    typedef struct packed {
        logic [15:0] cur_time;
        logic [2:0]  chosen;
        logic        idle;
        logic [1:0]  level;
        logic        done;
        logic [15:0] idle_ticks;
        logic [15:0] resp;
        logic [15:0] waited;
        logic [15:0] turn;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [2:0]  i_func = '0;
    logic [2:0]  i_proc_index = '0;
    logic [3:0]  i_entry_index = '0;
    logic [9:0]  i_entry_value = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [15:0] o_current_time;
    logic [2:0]  o_chosen_process;
    logic        o_cpu_idle;
    logic [1:0]  o_chosen_level;
    logic        o_all_done;
    logic [15:0] o_idle_ticks;
    logic [15:0] o_response_time;
    logic [15:0] o_wait_time;
    logic [15:0] o_turnaround_time;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    mlfq_process_scheduler_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_func(i_func), .i_proc_index(i_proc_index),
        .i_entry_index(i_entry_index), .i_entry_value(i_entry_value),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_current_time(o_current_time), .o_chosen_process(o_chosen_process),
        .o_cpu_idle(o_cpu_idle), .o_chosen_level(o_chosen_level),
        .o_all_done(o_all_done), .o_idle_ticks(o_idle_ticks),
        .o_response_time(o_response_time), .o_wait_time(o_wait_time),
        .o_turnaround_time(o_turnaround_time),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // scheduler shadow state
    logic [9:0]  cpu_tab [NPROC*NBURST];
    logic [9:0]  io_tab  [NPROC*NBURST];
    logic [4:0]  cpu_cnt [NPROC];
    logic [4:0]  io_cnt  [NPROC];
    mlfq_pkg::t_run_state rs [NPROC];
    logic [1:0]  lvl     [NPROC];
    logic [15:0] rdy     [NPROC];
    logic [3:0]  bpos    [NPROC];
    logic [3:0]  iopos   [NPROC];
    logic [9:0]  used    [NPROC];
    logic [15:0] first_run [NPROC];
    logic        has_run [NPROC];
    logic [15:0] waited  [NPROC];
    logic [15:0] fin     [NPROC];
    logic [15:0] tick, idles;
    logic [2:0]  prev;
    logic        prev_v, disp;
    logic [7:0]  q1, q2;
    logic [15:0] tlim;
    logic [3:0]  nuse;

    t_item   pending_items[$];
    t_result sched_results[$];
    int      errors = 0;
    int      results_seen = 0;
    bit      fast_tx = 0, fast_rx = 0;

    function automatic int unsigned n_used();
        if (nuse == 0) return 1;
        if (nuse > NPROC) return NPROC;
        return nuse;
    endfunction

    function automatic bit sched_finished();
        if (tick >= tlim) return 1'b1;
        for (int p = 0; p < n_used(); p++)
            if (rs[p] != mlfq_pkg::RS_DONE) return 1'b0;
        return 1'b1;
    endfunction

    function automatic int cpu_slot(int p);
        return p * NBURST + bpos[p];
    endfunction

    function automatic void burst_end(int p);
        rdy[p] = tick;
        used[p] = '0;
        disp = 1'b0;
        if (int'(bpos[p]) + 1 < int'(cpu_cnt[p])) begin
            bpos[p]++;
            rs[p] = mlfq_pkg::RS_IO;
        end else begin
            rs[p] = mlfq_pkg::RS_DONE;
            fin[p] = tick;
        end
    endfunction

    function automatic void tick_advance(bit cv, int c);
        int s;
        for (int p = 0; p < n_used(); p++)
            if (!(cv && p == c) && rs[p] == mlfq_pkg::RS_WAIT && waited[p] != 16'hFFFF)
                waited[p]++;
        for (int p = 0; p < n_used(); p++) begin
            if (rs[p] == mlfq_pkg::RS_IO) begin
                s = p * NBURST + iopos[p];
                if (io_tab[s] <= 1) begin
                    io_tab[s] = '0;
                    if (int'(iopos[p]) + 1 < int'(io_cnt[p])) iopos[p]++;
                    rs[p] = mlfq_pkg::RS_WAIT;
                    rdy[p] = tick;
                end else begin
                    io_tab[s]--;
                end
            end
        end
        if (tick != 16'hFFFF) tick++;
    endfunction

    function automatic void sched_round(output bit cv, output int ch);
        int unsigned best = NLEVEL, min_arr = 32'hFFFF_FFFF, rem, quant;
        int s, q;
        cv = 1'b0;
        ch = 0;
        for (int p = 0; p < n_used(); p++)
            if ((rs[p] == mlfq_pkg::RS_WAIT || rs[p] == mlfq_pkg::RS_EXEC) && lvl[p] < best)
                best = lvl[p];
        for (int p = 0; p < n_used(); p++)
            if ((rs[p] == mlfq_pkg::RS_WAIT || rs[p] == mlfq_pkg::RS_EXEC) &&
                lvl[p] == best && rdy[p] < min_arr) begin
                min_arr = rdy[p];
                ch = p;
                cv = 1'b1;
            end
        if (prev_v && (!cv || ch != prev)) begin
            q = prev;
            if (rs[q] == mlfq_pkg::RS_EXEC) begin
                s = cpu_slot(q);
                rem = cpu_tab[s] > used[q] ? cpu_tab[s] - used[q] : 0;
                cpu_tab[s] = rem[9:0];
                if (rem == 0) begin
                    burst_end(q);
                end else begin
                    rdy[q] = tick;
                    used[q] = '0;
                    rs[q] = mlfq_pkg::RS_WAIT;
                    disp = 1'b0;
                end
            end
        end
        if (!cv) begin
            tick_advance(1'b0, 0);
            if (idles != 16'hFFFF) idles++;
        end else if (rs[ch] == mlfq_pkg::RS_WAIT) begin
            if (!disp) begin
                used[ch] = '0;
                rs[ch] = mlfq_pkg::RS_EXEC;
                disp = 1'b1;
            end
        end else if (rs[ch] == mlfq_pkg::RS_EXEC) begin
            s = cpu_slot(ch);
            if (!has_run[ch]) begin
                first_run[ch] = tick;
                has_run[ch] = 1'b1;
            end
            if (used[ch] < cpu_tab[s]) begin
                quant = (lvl[ch] <= 1) ? q1 : q2;
                if (lvl[ch] >= NLEVEL || used[ch] < quant) begin
                    used[ch]++;
                    tick_advance(1'b1, ch);
                end else begin
                    rem = cpu_tab[s] > used[ch] ? cpu_tab[s] - used[ch] : 0;
                    cpu_tab[s] = rem[9:0];
                    lvl[ch]++;
                    used[ch] = '0;
                    rdy[ch] = tick;
                    disp = 1'b0;
                    rs[ch] = mlfq_pkg::RS_WAIT;
                end
            end else begin
                burst_end(ch);
            end
        end
        prev = ch[2:0];
        prev_v = cv;
    endfunction

    function automatic t_result predict_result(t_item it);
        t_result r;
        bit cv;
        int ch;
        r = '0;
        r.level = 2'd1;
        case (it.func)
            mlfq_pkg::FN_LOAD_CPU: cpu_tab[it.proc_idx * NBURST + it.entry_idx] = it.entry_val;
            mlfq_pkg::FN_LOAD_IO:  io_tab[it.proc_idx * NBURST + it.entry_idx] = it.entry_val;
            mlfq_pkg::FN_COUNTS: begin
                cpu_cnt[it.proc_idx] = it.entry_val > NBURST ? 5'(NBURST) : it.entry_val[4:0];
                io_cnt[it.proc_idx]  = {1'b0, it.entry_idx};
            end
            mlfq_pkg::FN_STEP: begin
                if (!sched_finished()) begin
                    sched_round(cv, ch);
                    if (cv) begin
                        r.chosen = ch[2:0];
                        r.level = lvl[ch];
                    end else begin
                        r.idle = 1'b1;
                    end
                end
            end
            mlfq_pkg::FN_READ: begin
                r.resp = first_run[it.proc_idx];
                r.waited = waited[it.proc_idx];
                r.turn = fin[it.proc_idx];
            end
            default: ;
        endcase
        r.cur_time = tick;
        r.done = sched_finished();
        r.idle_ticks = idles;
        return r;
    endfunction

    function automatic int pick_gap(bit fast);
        int r;
        if (fast) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // driver
    int tx_gap = 0;
    int tx_count = 0;
    always @(posedge i_clk) begin
        t_item it;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                sched_results.push_back(predict_result(
                    {i_func, i_proc_index, i_entry_index, i_entry_value}));
                tx_count++;
                if (tx_count % 150 == 0) fast_tx = ~fast_tx;
            end
            if (!i_valid || o_ready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    i_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    it = pending_items.pop_front();
                    i_func <= it.func;
                    i_proc_index <= it.proc_idx;
                    i_entry_index <= it.entry_idx;
                    i_entry_value <= it.entry_val;
                    i_valid <= 1'b1;
                    tx_gap = pick_gap(fast_tx);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    int  rx_gap = 0;
    int  hold_left = 0;
    bit  hold_done = 0;
    always @(posedge i_clk) begin
        t_result e, a;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                a = {o_current_time, o_chosen_process, o_cpu_idle, o_chosen_level,
                     o_all_done, o_idle_ticks, o_response_time, o_wait_time,
                     o_turnaround_time};
                results_seen++;
                if (results_seen % 170 == 0) fast_rx = ~fast_rx;
                if (sched_results.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected transaction: %p", a);
                end else begin
                    e = sched_results.pop_front();
                    if (a != e) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch at %0t: expected %p actual %p", $time, e, a);
                    end
                end
            end
            if (results_seen == 400 && !hold_done) begin
                hold_done = 1;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                rx_gap = pick_gap(fast_rx);
            end
        end
    end

    // watchdog
    int stuck = 0;
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            stuck = 0;
        else
            stuck++;
        if (stuck >= WDOG_MAX) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic add_item(logic [2:0] f, logic [2:0] p, logic [3:0] e, logic [9:0] v);
        pending_items.push_back({f, p, e, v});
    endtask

    task automatic drain();
        wait (pending_items.size() == 0 && sched_results.size() == 0 && !i_valid);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            mlfq_pkg::CFG_QUANT_ONE: q1 = data[7:0];
            mlfq_pkg::CFG_QUANT_TWO: q2 = data[7:0];
            mlfq_pkg::CFG_TIME_LIM:  tlim = data;
            mlfq_pkg::CFG_PROCS:     nuse = data[3:0];
            default: ;
        endcase
    endtask

    task automatic configure(int a, int b, int lim, int n);
        cfg_write(mlfq_pkg::CFG_QUANT_ONE, 16'(a));
        cfg_write(mlfq_pkg::CFG_QUANT_TWO, 16'(b));
        cfg_write(mlfq_pkg::CFG_TIME_LIM, lim > 65535 ? 16'hFFFF : 16'(lim));
        cfg_write(mlfq_pkg::CFG_PROCS, 16'(n));
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [9:0] burst_len();
        int r = $urandom_range(0, 99);
        if (r < 3) return 10'd1023;
        if (r < 8) return 10'd0;
        return 10'($urandom_range(1, 12));
    endfunction

    task automatic random_items(int count);
        int r;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            if (r < 55)
                add_item(mlfq_pkg::FN_STEP, 3'($urandom), 4'($urandom), 10'($urandom));
            else if (r < 65)
                add_item(mlfq_pkg::FN_LOAD_CPU, 3'($urandom), 4'($urandom), burst_len());
            else if (r < 72)
                add_item(mlfq_pkg::FN_LOAD_IO, 3'($urandom), 4'($urandom), burst_len());
            else if (r < 80)
                add_item(mlfq_pkg::FN_COUNTS, 3'($urandom), 4'($urandom),
                         $urandom_range(0, 9) == 0 ? 10'($urandom) :
                         10'($urandom_range(0, 20)));
            else if (r < 95)
                add_item(mlfq_pkg::FN_READ, 3'($urandom), 4'($urandom), 10'($urandom));
            else
                add_item(3'($urandom_range(5, 7)), 3'($urandom), 4'($urandom),
                         10'($urandom));
        end
    endtask

    initial begin
        for (int p = 0; p < NPROC; p++) begin
            cpu_cnt[p] = '0; io_cnt[p] = '0; rs[p] = mlfq_pkg::RS_WAIT; lvl[p] = 2'd1;
            rdy[p] = '0; bpos[p] = '0; iopos[p] = '0; used[p] = '0;
            first_run[p] = '0; has_run[p] = 1'b0; waited[p] = '0; fin[p] = '0;
        end
        tick = '0; idles = '0; prev = '0; prev_v = 1'b0; disp = 1'b0;
        q1 = 8'd5; q2 = 8'd10; tlim = 16'd590; nuse = 4'd8;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // every burst slot gets a known length before any step
        for (int p = 0; p < NPROC; p++)
            for (int b = 0; b < NBURST; b++) begin
                add_item(mlfq_pkg::FN_LOAD_CPU, 3'(p), 4'(b),
                         (p == 0 && b == 0) ? 10'd0 : 10'($urandom_range(1, 10)));
                add_item(mlfq_pkg::FN_LOAD_IO, 3'(p), 4'(b),
                         (b == 0) ? 10'(p % 2) : 10'($urandom_range(0, 8)));
            end
        add_item(mlfq_pkg::FN_LOAD_CPU, 3'd7, 4'd15, 10'd1023);
        add_item(mlfq_pkg::FN_COUNTS, 3'd0, 4'd0, 10'd0);
        add_item(mlfq_pkg::FN_COUNTS, 3'd1, 4'd15, 10'd1023);
        add_item(mlfq_pkg::FN_COUNTS, 3'd2, 4'd1, 10'd20);
        for (int p = 3; p < NPROC; p++)
            add_item(mlfq_pkg::FN_COUNTS, 3'(p), 4'($urandom_range(0, 4)),
                     10'($urandom_range(1, 4)));
        for (int k = 0; k < 10; k++) add_item(mlfq_pkg::FN_STEP, 3'd7, 4'hF, 10'h3FF);
        add_item(mlfq_pkg::FN_READ, 3'd0, 4'd0, 10'd0);
        add_item(mlfq_pkg::FN_READ, 3'd7, 4'hF, 10'h3FF);
        add_item(3'd5, 3'd1, 4'd1, 10'd1);
        add_item(3'd6, 3'd2, 4'd2, 10'd2);
        add_item(3'd7, 3'd3, 4'd3, 10'd3);
        random_items(370);
        drain();

        configure(1, 1, tick + 400, 1);
        random_items(300);
        drain();
        configure($urandom_range(1, 8), $urandom_range(1, 16), tick + 300, 3);
        random_items(300);
        drain();
        configure(2, 3, 1, 8);
        random_items(50);
        drain();
        configure($urandom_range(1, 8), $urandom_range(1, 16), tick + 500, 6);
        random_items(300);
        drain();
        configure(255, 255, 65535, 8);
        random_items(350);
        drain();

        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
`default_nettype wire

[mlfq_process_scheduler_top.f]
rtl/mlfq_pkg.sv
rtl/mlfq_ram.sv
rtl/mlfq_process_scheduler_top.sv
sim/tb_mlfq_process_scheduler_top.sv
